FILE: rtl/core/trs_transform_compose_unit_assert.svh
// Assertion macros for the transform compose unit.
// Depends on nothing; included by modules that check their own logic.
`ifndef TRS_TRANSFORM_COMPOSE_UNIT_ASSERT_SVH
`define TRS_TRANSFORM_COMPOSE_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TRS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define TRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/core/trs_pkg.sv
// Types, constants and helpers shared by the transform compose unit.
// Depends on nothing.
package trs_pkg;
  localparam int RsqrtIterations = 3;
  localparam logic [29:0] TinyLenSq = 30'd268;
  localparam logic [31:0] SeedLo = 32'd912680550;
  localparam logic [31:0] SeedHi = 32'd644245094;
  localparam logic signed [32:0] OneQ30 = 33'sd1073741824;

  typedef struct packed {
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } trs_in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] elem_c0;
    logic signed [31:0] elem_c1;
    logic signed [31:0] elem_c2;
    logic signed [31:0] elem_c3;
    logic               last_row;
  } trs_out_t;

  // Newton state handed from stage to stage.
  typedef struct packed {
    logic [31:0] m;
    logic [31:0] y;
    logic signed [4:0] e;
    logic        tiny;
  } trs_nwt_t;
endpackage

FILE: rtl/core/trs_newton_stage.sv
// One Newton step of the inverse square root, split over three registers.
// Depends on trs_pkg. Holds its data while en is low.
module trs_newton_stage import trs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     vld_i,
  input  trs_nwt_t d_i,
  output logic     vld_o,
  output trs_nwt_t d_o
);
  trs_nwt_t a_r, b_r, d_nxt;
  logic     va_r, vb_r;
  logic [31:0] y2_r, t_r;
  logic [63:0] yy, mt, yn;

  // The product y*y stays below 2^64 since y is below 2^32.
  assign yy = {32'd0, d_i.y} * {32'd0, d_i.y};
  assign mt = {32'd0, a_r.m} * {32'd0, y2_r};
  assign yn = {32'd0, b_r.y} * {32'd0, 32'hC000_0000 - t_r};

  always_comb begin
    d_nxt = b_r;
    d_nxt.y = yn[62:31];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0; vb_r <= 1'b0; vld_o <= 1'b0;
    end else if (en) begin
      va_r <= vld_i; vb_r <= va_r; vld_o <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= d_i; y2_r <= yy[61:30];
      b_r <= a_r; t_r <= mt[61:30];
      d_o <= d_nxt;
    end
  end
endmodule

FILE: rtl/core/trs_transform_compose_unit.sv
// Top level of the transform compose unit: range reduction, Newton steps,
// rotation build, scaling and the four-row output sequencer. Uses trs_pkg.
// Each transfer in produces four row transfers out, rows 0 to 3 in order. After
// each accepted item a spacing counter stalls the input, so the single result
// channel, sending one row per cycle unless stalled, sends all four rows of
// one item before the rows of the next; a new item is taken while earlier ones
// are still in the pipeline. A stall on the result side freezes the whole
// pipeline, so no item is lost or repeated.
module trs_transform_compose_unit import trs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  trs_in_t  in_data,
  input  logic     out_stall,
  output logic     out_valid,
  output trs_out_t out_data
);
  `include "trs_transform_compose_unit_assert.svh"

  logic en;
  logic [1:0] row_r;           // output row of the item in the last stage
  logic [1:0] gap_r;           // input spacing counter
  logic acc;

  // Pipeline advances unless a valid row is stalled.
  assign en = !(out_valid && out_stall);
  assign in_stall = !en || (gap_r != 2'd0);
  assign acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) gap_r <= 2'd0;
    else if (acc) gap_r <= 2'd3;
    else if (en && gap_r != 2'd0) gap_r <= gap_r - 2'd1;
  end

  // Stage 1: squared length. It reaches 2^32 when every component is -2.0.
  logic v1_r; trs_in_t d1_r; logic [32:0] l1_r;
  logic [31:0] sq_x, sq_y, sq_z, sq_w;
  assign sq_x = 32'(in_data.quat_x) * 32'(in_data.quat_x);
  assign sq_y = 32'(in_data.quat_y) * 32'(in_data.quat_y);
  assign sq_z = 32'(in_data.quat_z) * 32'(in_data.quat_z);
  assign sq_w = 32'(in_data.quat_w) * 32'(in_data.quat_w);
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= acc;
    if (en) begin
      d1_r <= in_data;
      l1_r <= {1'b0, sq_x} + {1'b0, sq_y} + {1'b0, sq_z} + {1'b0, sq_w};
    end
  end

  // Stage 2: range reduction of 4L into [2^30, 2^32) with exponent.
  logic v2_r; trs_in_t d2_r; trs_nwt_t n2, n2_r;
  always_comb begin
    logic [34:0] m;
    logic signed [4:0] k;
    m = {l1_r, 2'b00};
    k = '0;
    if (m[34:32] != 3'd0) begin
      m = m >> 2; k = -5'sd1;
      if (m[34:32] != 3'd0) begin
        m = m >> 2; k = -5'sd2;
      end
    end else begin
      for (int i = 0; i < 15; i++) begin
        if (m[31:30] == 2'd0) begin m = m << 2; k = k + 5'sd1; end
      end
    end
    n2.m = m[31:0];
    n2.y = m[31] ? SeedHi : SeedLo;
    n2.e = k;
    n2.tiny = (l1_r <= 33'(TinyLenSq));
  end
  trs_nwt_t nw [RsqrtIterations+1];
  logic     nv [RsqrtIterations+1];
  trs_in_t  dq [RsqrtIterations*3+1];
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
    if (en) begin d2_r <= d1_r; n2_r <= n2; end
  end
  assign nw[0] = n2_r;
  assign nv[0] = v2_r;
  assign dq[0] = d2_r;

  for (genvar g = 0; g < RsqrtIterations; g++) begin : g_nwt
    trs_newton_stage u_nwt (.clk, .rst_n, .en, .vld_i(nv[g]), .d_i(nw[g]),
                            .vld_o(nv[g+1]), .d_o(nw[g+1]));
  end
  for (genvar g = 0; g < RsqrtIterations*3; g++) begin : g_dly
    trs_in_t q_r;
    always_ff @(posedge clk) if (en) q_r <= dq[g];
    assign dq[g+1] = q_r;
  end

  // Stage 3: normalized components, Q.30.
  trs_nwt_t nf; trs_in_t df;
  assign nf = nw[RsqrtIterations];
  assign df = dq[RsqrtIterations*3];
  logic v3_r; trs_in_t d3_r; logic tiny3_r;
  logic signed [32:0] nx_r, ny_r, nz_r, nw_r;
  function automatic logic signed [32:0] nrm(logic signed [15:0] q,
                                             logic [31:0] y, logic signed [4:0] e);
    logic signed [48:0] p;
    logic [4:0] sh;
    p = q * $signed({1'b0, y});
    sh = 5'(5'sd14 - e);
    return 33'(p >>> sh);
  endfunction
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= nv[RsqrtIterations];
    if (en) begin
      d3_r <= df; tiny3_r <= nf.tiny;
      nx_r <= nrm(df.quat_x, nf.y, nf.e);
      ny_r <= nrm(df.quat_y, nf.y, nf.e);
      nz_r <= nrm(df.quat_z, nf.y, nf.e);
      nw_r <= nrm(df.quat_w, nf.y, nf.e);
    end
  end

  // Stage 4: pairwise products.
  function automatic logic signed [34:0] pm(logic signed [32:0] a, logic signed [32:0] b);
    logic signed [65:0] p;
    p = a * b;
    return 35'(p >>> 30);
  endfunction
  logic v4_r; trs_in_t d4_r; logic tiny4_r;
  logic signed [34:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
    if (en) begin
      d4_r <= d3_r; tiny4_r <= tiny3_r;
      xx_r <= pm(nx_r, nx_r); yy_r <= pm(ny_r, ny_r); zz_r <= pm(nz_r, nz_r);
      xy_r <= pm(nx_r, ny_r); xz_r <= pm(nx_r, nz_r); yz_r <= pm(ny_r, nz_r);
      wx_r <= pm(nw_r, nx_r); wy_r <= pm(nw_r, ny_r); wz_r <= pm(nw_r, nz_r);
    end
  end

  // Stage 5: rotation elements.
  logic v5_r; trs_in_t d5_r;
  logic signed [37:0] rot_r [3][3];
  logic signed [37:0] rot_nxt [3][3];
  always_comb begin
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        rot_nxt[r][c] = (r == c) ? 38'(OneQ30) : '0;
    if (!tiny4_r) begin
      rot_nxt[0][0] = 38'(OneQ30) - 38'((yy_r + zz_r) <<< 1);
      rot_nxt[0][1] = 38'((xy_r - wz_r) <<< 1);
      rot_nxt[0][2] = 38'((xz_r + wy_r) <<< 1);
      rot_nxt[1][0] = 38'((xy_r + wz_r) <<< 1);
      rot_nxt[1][1] = 38'(OneQ30) - 38'((xx_r + zz_r) <<< 1);
      rot_nxt[1][2] = 38'((yz_r - wx_r) <<< 1);
      rot_nxt[2][0] = 38'((xz_r - wy_r) <<< 1);
      rot_nxt[2][1] = 38'((yz_r + wx_r) <<< 1);
      rot_nxt[2][2] = 38'(OneQ30) - 38'((xx_r + yy_r) <<< 1);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
    if (en) begin
      d5_r <= d4_r;
      rot_r <= rot_nxt;
    end
  end

  // Stage 6: scaling and saturation, one row per cycle while not stalled, from a held item.
  logic hv_r; trs_in_t hd_r; logic signed [37:0] hrot_r [3][3];
  logic [1:0] hrow_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin hv_r <= 1'b0; hrow_r <= '0; end
    else if (en) begin
      if (v5_r) begin hv_r <= 1'b1; hrow_r <= '0; end
      else if (hv_r) begin
        hrow_r <= hrow_r + 2'd1;
        if (hrow_r == 2'd3) hv_r <= 1'b0;
      end
    end
    if (en && v5_r) begin hd_r <= d5_r; hrot_r <= rot_r; end
  end

  function automatic logic signed [31:0] scl(logic signed [37:0] r, logic signed [31:0] s);
    logic signed [69:0] p;
    logic signed [39:0] q;
    p = r * s + 70'sd536870912;
    q = 40'(p >>> 30);
    if (q > 40'sd2147483647) return 32'h7FFF_FFFF;
    if (q < -40'sd2147483648) return 32'h8000_0000;
    return q[31:0];
  endfunction

  trs_out_t o;
  always_comb begin
    logic [1:0] rr;
    rr = (hrow_r == 2'd3) ? 2'd0 : hrow_r;
    o.row_index = hrow_r;
    o.last_row = (hrow_r == 2'd3);
    o.elem_c0 = scl(hrot_r[rr][0], hd_r.scale_x);
    o.elem_c1 = scl(hrot_r[rr][1], hd_r.scale_y);
    o.elem_c2 = scl(hrot_r[rr][2], hd_r.scale_z);
    case (hrow_r)
      2'd0: o.elem_c3 = hd_r.trans_x;
      2'd1: o.elem_c3 = hd_r.trans_y;
      2'd2: o.elem_c3 = hd_r.trans_z;
      default: o.elem_c3 = 32'h0001_0000;
    endcase
    if (hrow_r == 2'd3) begin o.elem_c0 = '0; o.elem_c1 = '0; o.elem_c2 = '0; end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin out_valid <= 1'b0; row_r <= '0; end
    else if (en) begin out_valid <= hv_r; row_r <= hrow_r; end
    if (en) out_data <= o;
  end

  `TRS_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `TRS_ASSERT_IMP(a_last, out_valid, out_data.last_row == (out_data.row_index == 2'd3))
  `TRS_ASSERT_IMP(a_row, out_valid, row_r == out_data.row_index)
  `TRS_ASSERT_NEXT(a_gap, acc, in_stall)
endmodule
